// ===== rtl/mwvm_pkg.sv =====
// Shared types, constants and the arctangent table of the mecanum wheel mixer.
`default_nettype none

package mwvm_pkg;

  // Default number of heading bits used by the rotation pipeline.
  localparam int HEADING_BITS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;

  // Width of the cosine and sine values, Q0.30 in a signed 32-bit word.
  localparam int TRIG_W = 32;
  localparam logic signed [TRIG_W-1:0] CORDIC_K = 32'sd652032874;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARM_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RPM_GAIN   = 2'd2;

  // Frame mode register codes; the spare code behaves as standby.
  localparam logic [1:0] MODE_STANDBY = 2'd0;
  localparam logic [1:0] MODE_ROBOT   = 2'd1;
  localparam logic [1:0] MODE_WORLD   = 2'd2;

  // Queue between the rotation front end and the wheel back end.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Class that the front end gives each request.
  typedef enum logic [1:0] {
    CLS_STANDBY = 2'd0,
    CLS_ROBOT   = 2'd1,
    CLS_WORLD   = 2'd2
  } frame_cls_t;

  typedef struct packed {
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
    logic signed [15:0] turn_rate;
    logic        [15:0] heading;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] rpm_right_front;
    logic signed [15:0] rpm_right_back;
    logic signed [15:0] rpm_left_back;
    logic signed [15:0] rpm_left_front;
    logic               saturated;
  } out_item_t;

  // Request as it leaves the front end: class, speeds and heading trig values.
  typedef struct packed {
    frame_cls_t                cls;
    logic signed [15:0]        speed_x;
    logic signed [15:0]        speed_y;
    logic signed [15:0]        turn_rate;
    logic signed [TRIG_W-1:0]  cos_v;
    logic signed [TRIG_W-1:0]  sin_v;
  } trig_item_t;

  // Arctangent of 2^-idx as a fraction of a full turn, 2^32 per turn.
  function automatic logic signed [TRIG_W-1:0] atan_turn(input int idx);
    logic signed [TRIG_W-1:0] v;
    case (idx)
      0:       v = 32'sh20000000;
      1:       v = 32'sh12E4051E;
      2:       v = 32'sh09FB385B;
      3:       v = 32'sh051111D4;
      4:       v = 32'sh028B0D43;
      5:       v = 32'sh0145D7E1;
      6:       v = 32'sh00A2F61E;
      7:       v = 32'sh00517C55;
      8:       v = 32'sh0028BE53;
      9:       v = 32'sh00145F2F;
      10:      v = 32'sh000A2F98;
      11:      v = 32'sh000517CC;
      12:      v = 32'sh00028BE6;
      13:      v = 32'sh000145F3;
      14:      v = 32'sh0000A2FA;
      15:      v = 32'sh0000517D;
      16:      v = 32'sh000028BE;
      17:      v = 32'sh0000145F;
      18:      v = 32'sh00000A30;
      19:      v = 32'sh00000518;
      20:      v = 32'sh0000028C;
      21:      v = 32'sh00000146;
      22:      v = 32'sh000000A3;
      23:      v = 32'sh00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mwvm_front.sv =====
// Front end: accepts requests, classifies the frame and runs the pipelined CORDIC.
`default_nettype none

module mwvm_front
  import mwvm_pkg::*;
#(
  parameter int HEADING_BITS = HEADING_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] frame_mode,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       trig_valid,
  input  logic       trig_ready,
  output trig_item_t trig_data
);

  localparam int NSTG = HEADING_BITS;
  localparam logic [31:0] ANGLE_MASK = 32'hFFFF_FFFF << (32 - HEADING_BITS);

  logic                     vld_r  [0:NSTG];
  logic signed [TRIG_W-1:0] x_r    [0:NSTG];
  logic signed [TRIG_W-1:0] y_r    [0:NSTG];
  logic signed [31:0]       z_r    [0:NSTG];
  logic                     flip_r [0:NSTG];
  frame_cls_t               cls_r  [0:NSTG];
  logic signed [15:0]       sx_r   [0:NSTG];
  logic signed [15:0]       sy_r   [0:NSTG];
  logic signed [15:0]       w_r    [0:NSTG];

  logic        adv;
  logic [31:0] ang_raw;
  logic [31:0] ang_quad;
  logic        flip_nxt;
  logic [31:0] z_nxt;
  frame_cls_t  cls_nxt;

  // The whole pipeline moves unless its last request is blocked by a full queue.
  assign adv      = !vld_r[NSTG] || trig_ready;
  assign in_ready = adv;

  // Fold the heading into the half turn around zero; the far half is negated later.
  always_comb begin
    ang_raw  = {in_data.heading, 16'h0000} & ANGLE_MASK;
    ang_quad = ang_raw + 32'h4000_0000;
    flip_nxt = ang_quad[31];
    z_nxt    = flip_nxt ? {~ang_raw[31], ang_raw[30:0]} : ang_raw;
  end

  // Classify the request by the frame mode in force.
  always_comb begin
    case (frame_mode)
      MODE_ROBOT: cls_nxt = CLS_ROBOT;
      MODE_WORLD: cls_nxt = CLS_WORLD;
      default:    cls_nxt = CLS_STANDBY;
    endcase
  end

  // Entry register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]    <= CORDIC_K;
      y_r[0]    <= '0;
      z_r[0]    <= signed'(z_nxt);
      flip_r[0] <= flip_nxt;
      cls_r[0]  <= cls_nxt;
      sx_r[0]   <= in_data.speed_x;
      sy_r[0]   <= in_data.speed_y;
      w_r[0]    <= in_data.turn_rate;
    end
  end

  // One CORDIC rotation step per stage.
  for (genvar k = 0; k < NSTG; k++) begin : g_iter
    logic signed [TRIG_W-1:0] dx;
    logic signed [TRIG_W-1:0] dy;
    logic signed [TRIG_W-1:0] xs_nxt;
    logic signed [TRIG_W-1:0] ys_nxt;
    logic signed [31:0]       zs_nxt;

    assign dx = y_r[k] >>> k;
    assign dy = x_r[k] >>> k;

    always_comb begin
      if (!z_r[k][31]) begin
        xs_nxt = x_r[k] - dx;
        ys_nxt = y_r[k] + dy;
        zs_nxt = z_r[k] - atan_turn(k);
      end else begin
        xs_nxt = x_r[k] + dx;
        ys_nxt = y_r[k] - dy;
        zs_nxt = z_r[k] + atan_turn(k);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[k+1]    <= xs_nxt;
        y_r[k+1]    <= ys_nxt;
        z_r[k+1]    <= zs_nxt;
        flip_r[k+1] <= flip_r[k];
        cls_r[k+1]  <= cls_r[k];
        sx_r[k+1]   <= sx_r[k];
        sy_r[k+1]   <= sy_r[k];
        w_r[k+1]    <= w_r[k];
      end
    end
  end

  // Undo the half-turn fold and hand the request to the queue.
  assign trig_valid = vld_r[NSTG];

  always_comb begin
    trig_data.cls       = cls_r[NSTG];
    trig_data.speed_x   = sx_r[NSTG];
    trig_data.speed_y   = sy_r[NSTG];
    trig_data.turn_rate = w_r[NSTG];
    trig_data.cos_v     = flip_r[NSTG] ? -x_r[NSTG] : x_r[NSTG];
    trig_data.sin_v     = flip_r[NSTG] ? -y_r[NSTG] : y_r[NSTG];
  end

endmodule

`default_nettype wire

// ===== rtl/mwvm_fifo.sv =====
// Short request queue between the front end and the back end.
`default_nettype none

module mwvm_fifo
  import mwvm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  trig_item_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output trig_item_t pop_data
);

  localparam logic [FIFO_CNT_W-1:0] FULL_CNT = FIFO_CNT_W'(FIFO_DEPTH);

  trig_item_t              mem_r [0:FIFO_DEPTH-1];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r;
  logic [FIFO_CNT_W-1:0]   cnt_r;
  logic [FIFO_CNT_W-1:0]   cnt_nxt;
  logic                    do_push;
  logic                    do_pop;

  assign push_ready = (cnt_r != FULL_CNT);
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Occupancy follows pushes and pops.
  always_comb begin
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Storage needs no reset; entries are only read once written.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mwvm_back.sv =====
// Back end: frame rotation, wheel sums, rpm scaling, rounding and saturation.
`default_nettype none

module mwvm_back
  import mwvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [11:0] arm_length_mm,
  input  logic [23:0] rpm_gain,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  trig_item_t  pop_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  localparam logic signed [48:0] ROUND_Q30 = 49'sd536870912;
  localparam logic signed [56:0] ROUND_RPM = 57'sd17179869184;

  // Clips a rounded wheel value to 16 bits; the top bit flags a clip.
  function automatic logic [16:0] clip16(input logic signed [22:0] v);
    logic [16:0] r;
    if (v > 23'sd32767) begin
      r = {1'b1, 16'h7FFF};
    end else if (v < -23'sd32768) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b0, v[15:0]};
    end
    return r;
  endfunction

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;

  // Stage 1: rotation products and the turn term.
  logic signed [47:0] p_cx_r, p_sy_r, p_cy_r, p_sx_r;
  logic signed [28:0] turn1_r;
  frame_cls_t         cls1_r;
  logic signed [15:0] sx1_r, sy1_r;

  // Stage 2: frame speeds.
  logic signed [48:0] rot_x, rot_y;
  logic signed [18:0] tx_nxt, ty_nxt;
  logic signed [18:0] tx2_r, ty2_r;
  logic signed [28:0] turn2_r;

  // Stage 3: wheel sums in 2^-11 mm/s.
  logic signed [31:0] tx_w, ty_w, turn_w;
  logic signed [31:0] sum_rf_r, sum_rb_r, sum_lb_r, sum_lf_r;

  // Stage 4: scaled sums.
  logic signed [24:0] gain_s;
  logic signed [56:0] prod_rf_r, prod_rb_r, prod_lb_r, prod_lf_r;

  // Stage 5: rounded, sign-flipped and clipped.
  logic signed [56:0] rnd_rf, rnd_rb, rnd_lb, rnd_lf;
  logic signed [22:0] rpm_rf, rpm_rb, rpm_lb, rpm_lf;
  logic [16:0]        clip_rf, clip_rb, clip_lb, clip_lf;
  out_item_t          out_nxt;
  out_item_t          out_data_r;

  // The pipeline moves whenever the output register is free or being emptied.
  assign adv       = !out_valid_r || out_ready;
  assign pop_ready = adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= pop_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  // Stage 1 registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      p_cx_r  <= pop_data.cos_v * pop_data.speed_x;
      p_sy_r  <= pop_data.sin_v * pop_data.speed_y;
      p_cy_r  <= pop_data.cos_v * pop_data.speed_y;
      p_sx_r  <= pop_data.sin_v * pop_data.speed_x;
      turn1_r <= pop_data.turn_rate * signed'({1'b0, arm_length_mm});
      cls1_r  <= pop_data.cls;
      sx1_r   <= pop_data.speed_x;
      sy1_r   <= pop_data.speed_y;
    end
  end

  // Rotate by the heading, round half up, and pick the speeds for the class.
  always_comb begin
    rot_x = p_cx_r + p_sy_r + ROUND_Q30;
    rot_y = p_cy_r - p_sx_r + ROUND_Q30;
    case (cls1_r)
      CLS_WORLD: begin
        tx_nxt = rot_x[48:30];
        ty_nxt = rot_y[48:30];
      end
      CLS_ROBOT: begin
        tx_nxt = 19'(sx1_r);
        ty_nxt = 19'(sy1_r);
      end
      default: begin
        tx_nxt = '0;
        ty_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tx2_r   <= tx_nxt;
      ty2_r   <= ty_nxt;
      turn2_r <= turn1_r;
    end
  end

  // Wheel sums: the right side subtracts the turn term, the left side adds it.
  assign tx_w   = 32'(tx2_r) <<< 11;
  assign ty_w   = 32'(ty2_r) <<< 11;
  assign turn_w = 32'(turn2_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_rf_r <= ty_w + tx_w - turn_w;
      sum_rb_r <= ty_w - tx_w - turn_w;
      sum_lb_r <= ty_w + tx_w + turn_w;
      sum_lf_r <= ty_w - tx_w + turn_w;
    end
  end

  // Scale by the rpm gain.
  assign gain_s = signed'({1'b0, rpm_gain});

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_rf_r <= sum_rf_r * gain_s;
      prod_rb_r <= sum_rb_r * gain_s;
      prod_lb_r <= sum_lb_r * gain_s;
      prod_lf_r <= sum_lf_r * gain_s;
    end
  end

  // Round half up to whole rpm, negate the left wheels, then clip.
  always_comb begin
    rnd_rf  = prod_rf_r + ROUND_RPM;
    rnd_rb  = prod_rb_r + ROUND_RPM;
    rnd_lb  = prod_lb_r + ROUND_RPM;
    rnd_lf  = prod_lf_r + ROUND_RPM;
    rpm_rf  = 23'(rnd_rf >>> 35);
    rpm_rb  = 23'(rnd_rb >>> 35);
    rpm_lb  = -23'(rnd_lb >>> 35);
    rpm_lf  = -23'(rnd_lf >>> 35);
    clip_rf = clip16(rpm_rf);
    clip_rb = clip16(rpm_rb);
    clip_lb = clip16(rpm_lb);
    clip_lf = clip16(rpm_lf);
    out_nxt.rpm_right_front = clip_rf[15:0];
    out_nxt.rpm_right_back  = clip_rb[15:0];
    out_nxt.rpm_left_back   = clip_lb[15:0];
    out_nxt.rpm_left_front  = clip_lf[15:0];
    out_nxt.saturated       = clip_rf[16] | clip_rb[16] | clip_lb[16] | clip_lf[16];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mecanum_wheel_velocity_mixer_core.sv =====
// Top level of the mecanum wheel mixer: configuration registers, front end, queue, back end.
//
// Usage
//   Input channel in_valid/in_ready/in_data carries one request: x and y speed, turn rate
//   and heading. Output channel out_valid/out_ready/out_data returns the four wheel rpm
//   values and a saturation flag, one result per request, in request order.
//   The configuration port (cfg_we, cfg_index, cfg_wdata) writes frame mode, arm length
//   and rpm gain; write it only while no request is in flight.
// Timing
//   One request per cycle is accepted and one result per cycle is delivered while
//   out_ready stays high. A request passes the entry register and the one-step-per-stage
//   CORDIC in the front end, the queue register and the five back-end stages.
// Reset and stalls
//   Reset empties the pipelines and the queue and clears all three registers, which
//   puts the block in standby. When the receiver holds out_ready low the back end
//   holds its result, the four-entry queue fills from the front end, and once it is
//   full the front end stops and in_ready drops.
`default_nettype none

module mecanum_wheel_velocity_mixer_core
  import mwvm_pkg::*;
#(
  parameter int HEADING_BITS = HEADING_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [1:0]  frame_mode_r;
  logic [11:0] arm_length_mm_r;
  logic [23:0] rpm_gain_r;

  logic        trig_valid;
  logic        trig_ready;
  trig_item_t  trig_data;
  logic        pop_valid;
  logic        pop_ready;
  trig_item_t  pop_data;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_mode_r    <= MODE_STANDBY;
      arm_length_mm_r <= '0;
      rpm_gain_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_MODE: frame_mode_r    <= cfg_wdata[1:0];
        CFG_ARM_LENGTH: arm_length_mm_r <= cfg_wdata[11:0];
        CFG_RPM_GAIN:   rpm_gain_r      <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  mwvm_front #(
    .HEADING_BITS (HEADING_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_mode (frame_mode_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .trig_valid (trig_valid),
    .trig_ready (trig_ready),
    .trig_data  (trig_data)
  );

  mwvm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (trig_valid),
    .push_ready (trig_ready),
    .push_data  (trig_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mwvm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .arm_length_mm (arm_length_mm_r),
    .rpm_gain      (rpm_gain_r),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

  // A front end blocked by a full queue must not take a new request.
  a_front_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    trig_valid && !trig_ready |-> !in_ready)
    else $error("request accepted while the front end is blocked");

  // The queue head holds while the back end is stalled.
  a_queue_holds: assert property (@(posedge clk) disable iff (!rst_n)
    pop_valid && !pop_ready |=> pop_valid && $stable(pop_data))
    else $error("queue head changed while the back end was stalled");

  // A clipped wheel always shows a full-scale value.
  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.rpm_right_front == 16'sh7FFF || out_data.rpm_right_front == -16'sh8000 ||
      out_data.rpm_right_back  == 16'sh7FFF || out_data.rpm_right_back  == -16'sh8000 ||
      out_data.rpm_left_back   == 16'sh7FFF || out_data.rpm_left_back   == -16'sh8000 ||
      out_data.rpm_left_front  == 16'sh7FFF || out_data.rpm_left_front  == -16'sh8000)
    else $error("saturation flag set without a full-scale wheel value");

endmodule

`default_nettype wire
